/* src/pfa_pkg.sv */
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared types and constants for the page frame allocator: operation codes,
// controller states and the command / status bundles between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package pfa_pkg;

    // default sizing
    localparam int NUM_FRAMES_DEF  = 1024;
    localparam int COUNT_WIDTH_DEF = 16;

    // fixed field widths
    localparam int OP_W    = 2;
    localparam int INDEX_W = 10;
    localparam int LEN_W   = 11;
    localparam int TOTAL_W = 11;

    // managed frame register after reset
    localparam logic [TOTAL_W-1:0] FRAMES_RESET = 11'd1024;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC   = 2'd0,
        OP_FREE    = 2'd1,
        OP_RESERVE = 2'd2,
        OP_COUNT   = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN,
        ST_SKIP,
        ST_FILL,
        ST_RMW,
        ST_COUNT,
        ST_DONE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic clr_wr;      // write zero at pointer, advance
        logic load_item;   // capture input transaction
        logic issue_rd;    // read table at pointer, advance
        logic zero_acc;    // count a returned zero entry
        logic rmw_wr;      // write back updated count of returned entry
        logic s_step;      // move candidate start by one alignment step
        logic ptr_from_s;  // pointer to candidate start
        logic acc_clr;     // clear run / zero counter
        logic fill_wr;     // write one at pointer, advance
        logic res_load;    // load result register
        logic res_ok;      // success flag of the result
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        op_t  item_op;
        logic clr_last;
        logic rd_more;
        logic chk_vld;
        logic chk_zero;
        logic run_done;
        logic skip_more;
        logic fit;
        logic len_ok;
        logic fill_last;
        logic out_free;
    } sts_t;

endpackage

/* src/refcounted_page_frame_allocator.sv */
// ----------------------------------------------------------------------------
// refcounted_page_frame_allocator
// Reference-counted physical page frame allocator: first-fit aligned run
// allocation, run free / reserve and free / used totals.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel carries one operation per transaction (allocate, free,
//   reserve, count); m_* channel returns exactly one result per operation.
//   cfg_* sets the number of managed frames (clamped to NUM_FRAMES); it is
//   always ready and must only be written while no operation is in flight.
// Reset: the count table is cleared by a sweep over all NUM_FRAMES entries,
//   one entry per cycle; s_ready stays low until it finishes.
// Operation: one operation at a time, the table has one read and one write
//   port and is walked one entry per cycle.
//   count:          reads every managed frame
//   free / reserve: updates the frames of the run inside the managed range
//   allocate:       examines frames from the candidate start, moves the
//                   start in alignment steps past each used frame hit,
//                   then fills the run
// Stall: a finished result sits in the output register; the next operation
//   is accepted meanwhile and is held in its last cycle until m_ready.
// ----------------------------------------------------------------------------
module refcounted_page_frame_allocator #(
    parameter int NUM_FRAMES  = pfa_pkg::NUM_FRAMES_DEF,
    parameter int COUNT_WIDTH = pfa_pkg::COUNT_WIDTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pfa_pkg::TOTAL_W-1:0]      cfg_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [pfa_pkg::OP_W-1:0]         s_operation,
    input  logic [pfa_pkg::INDEX_W-1:0]      s_frame_index,
    input  logic [pfa_pkg::LEN_W-1:0]        s_run_length,
    input  logic [pfa_pkg::LEN_W-1:0]        s_align_step,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_success,
    output logic [pfa_pkg::INDEX_W-1:0]      m_first_frame,
    output logic [pfa_pkg::TOTAL_W-1:0]      m_free_total,
    output logic [pfa_pkg::TOTAL_W-1:0]      m_used_total
);
    import pfa_pkg::*;

    localparam int PW = $clog2(NUM_FRAMES + 1);
    localparam int CW = (PW > 12) ? PW : 12;

    logic [TOTAL_W-1:0] frames_reg;
    logic [CW-1:0]      total;
    cmd_t               cmd;
    sts_t               sts;

    // managed frame register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frames_reg <= FRAMES_RESET;
        end else if (cfg_valid) begin
            frames_reg <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;

    // clamp to the table size
    assign total = (CW'(frames_reg) > CW'(NUM_FRAMES)) ? CW'(NUM_FRAMES) : CW'(frames_reg);

    pfa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    pfa_datapath #(
        .NUM_FRAMES  (NUM_FRAMES),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .total         (total),
        .cmd           (cmd),
        .sts           (sts),
        .s_operation   (s_operation),
        .s_frame_index (s_frame_index),
        .s_run_length  (s_run_length),
        .s_align_step  (s_align_step),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_success     (m_success),
        .m_first_frame (m_first_frame),
        .m_free_total  (m_free_total),
        .m_used_total  (m_used_total)
    );

endmodule

/* src/pfa_ctrl.sv */
// ----------------------------------------------------------------------------
// pfa_ctrl
// Controller state machine: table clear after reset, operation dispatch,
// first-fit scan with alignment skip, run fill, read-modify-write stream,
// free count stream and result hand-off.
// ----------------------------------------------------------------------------
module pfa_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  pfa_pkg::sts_t sts,
    output pfa_pkg::cmd_t cmd
);
    import pfa_pkg::*;

    state_t state_reg, state_next;
    logic   ok_reg, ok_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            ok_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            ok_reg    <= ok_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        ok_next    = ok_reg;
        cmd        = '0;
        cmd.res_ok = ok_reg;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                ok_next = 1'b1;
                unique case (sts.item_op) inside
                    OP_ALLOC: begin
                        if (sts.len_ok) begin
                            state_next = ST_SCAN;
                        end else begin
                            ok_next    = 1'b0;
                            state_next = ST_DONE;
                        end
                    end
                    OP_FREE, OP_RESERVE: state_next = ST_RMW;
                    default:             state_next = ST_COUNT;
                endcase
            end
            // stream reads from the candidate start, stop on a hit or a full run
            ST_SCAN: begin
                if (sts.chk_vld && !sts.chk_zero) begin
                    state_next = ST_SKIP;
                end else if (sts.chk_vld && sts.run_done) begin
                    cmd.ptr_from_s = 1'b1;
                    state_next     = ST_FILL;
                end else begin
                    cmd.zero_acc = 1'b1;
                    cmd.issue_rd = sts.rd_more;
                end
            end
            // next aligned start past the used frame, or fail if the run no longer fits
            ST_SKIP: begin
                if (sts.skip_more) begin
                    cmd.s_step = 1'b1;
                end else if (sts.fit) begin
                    cmd.ptr_from_s = 1'b1;
                    cmd.acc_clr    = 1'b1;
                    state_next     = ST_SCAN;
                end else begin
                    ok_next    = 1'b0;
                    state_next = ST_DONE;
                end
            end
            ST_FILL: begin
                cmd.fill_wr = 1'b1;
                if (sts.fill_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_RMW: begin
                cmd.rmw_wr   = 1'b1;
                cmd.issue_rd = sts.rd_more;
                if (!sts.rd_more && !sts.chk_vld) begin
                    state_next = ST_DONE;
                end
            end
            ST_COUNT: begin
                cmd.zero_acc = 1'b1;
                cmd.issue_rd = sts.rd_more;
                if (!sts.rd_more && !sts.chk_vld) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.res_load |-> sts.out_free)
        else $error("result loaded while previous result still pending");

    // one transaction at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input still ready after accepting a transaction");
`endif

endmodule

/* src/pfa_datapath.sv */
// ----------------------------------------------------------------------------
// pfa_datapath
// Reference count table (one write, one registered read port), scan pointer,
// candidate start, run / zero counter, item registers and result register.
// ----------------------------------------------------------------------------
module pfa_datapath #(
    parameter int NUM_FRAMES  = pfa_pkg::NUM_FRAMES_DEF,
    parameter int COUNT_WIDTH = pfa_pkg::COUNT_WIDTH_DEF,
    localparam int PW = $clog2(NUM_FRAMES + 1),
    localparam int CW = (PW > 12) ? PW : 12
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [CW-1:0]                    total,
    input  pfa_pkg::cmd_t                    cmd,
    output pfa_pkg::sts_t                    sts,
    input  logic [pfa_pkg::OP_W-1:0]         s_operation,
    input  logic [pfa_pkg::INDEX_W-1:0]      s_frame_index,
    input  logic [pfa_pkg::LEN_W-1:0]        s_run_length,
    input  logic [pfa_pkg::LEN_W-1:0]        s_align_step,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_success,
    output logic [pfa_pkg::INDEX_W-1:0]      m_first_frame,
    output logic [pfa_pkg::TOTAL_W-1:0]      m_free_total,
    output logic [pfa_pkg::TOTAL_W-1:0]      m_used_total
);
    import pfa_pkg::*;

    localparam int AW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int SW = CW + 1;

    // reference count table
    logic [COUNT_WIDTH-1:0] mem [NUM_FRAMES];

    logic [CW-1:0]          ptr_reg, ptr_next;
    logic [CW-1:0]          chk_addr_reg;
    logic                   chk_vld_reg;
    logic [COUNT_WIDTH-1:0] rdata_reg;
    logic [SW-1:0]          s_reg, s_next;
    logic [CW-1:0]          acc_reg, acc_next;
    op_t                    op_reg;
    logic [INDEX_W-1:0]     idx_reg;
    logic [LEN_W-1:0]       len_reg;
    logic [LEN_W-1:0]       step_reg;
    logic                   m_valid_reg;
    logic                   success_reg;
    logic [INDEX_W-1:0]     first_reg;
    logic [TOTAL_W-1:0]     free_reg;
    logic [TOTAL_W-1:0]     used_reg;

    logic [LEN_W-1:0]       step_eff;
    logic [SW-1:0]          len_w, total_w, run_end, rmw_raw, rmw_end, rd_lim;
    logic [CW-1:0]          used_w;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [COUNT_WIDTH-1:0] wr_data, upd_data;

    // range arithmetic
    always_comb begin
        step_eff = (step_reg == '0) ? LEN_W'(1) : step_reg;
        len_w    = SW'(len_reg);
        total_w  = SW'(total);
        run_end  = s_reg + len_w;
        rmw_raw  = SW'(idx_reg) + len_w;
        rmw_end  = (rmw_raw < total_w) ? rmw_raw : total_w;
        case (op_reg)
            OP_ALLOC: rd_lim = run_end;
            OP_COUNT: rd_lim = total_w;
            default:  rd_lim = rmw_end;
        endcase
        used_w = total - acc_reg;
    end

    // status to controller
    always_comb begin
        sts.item_op   = op_reg;
        sts.clr_last  = (ptr_reg == CW'(NUM_FRAMES - 1));
        sts.rd_more   = (SW'(ptr_reg) < rd_lim);
        sts.chk_vld   = chk_vld_reg;
        sts.chk_zero  = (rdata_reg == '0);
        sts.run_done  = (SW'(acc_reg) + SW'(1) == len_w);
        sts.skip_more = (s_reg <= SW'(chk_addr_reg));
        sts.fit       = (run_end <= total_w);
        sts.len_ok    = (len_reg != '0) && (len_w <= total_w);
        sts.fill_last = (SW'(ptr_reg) == run_end - SW'(1));
        sts.out_free  = !m_valid_reg || m_ready;
    end

    // decrement to zero / saturating increment
    always_comb begin
        if (op_reg == OP_FREE) begin
            upd_data = (rdata_reg != '0) ? rdata_reg - COUNT_WIDTH'(1) : rdata_reg;
        end else begin
            upd_data = (rdata_reg != '1) ? rdata_reg + COUNT_WIDTH'(1) : rdata_reg;
        end
    end

    // table write port select
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = ptr_reg[AW-1:0];
        wr_data = '0;
        if (cmd.clr_wr) begin
            wr_en = 1'b1;
        end else if (cmd.fill_wr) begin
            wr_en   = 1'b1;
            wr_data = COUNT_WIDTH'(1);
        end else if (cmd.rmw_wr && chk_vld_reg) begin
            wr_en   = 1'b1;
            wr_addr = chk_addr_reg[AW-1:0];
            wr_data = upd_data;
        end
    end

    // table ports
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.issue_rd) begin
            rdata_reg    <= mem[ptr_reg[AW-1:0]];
            chk_addr_reg <= ptr_reg;
        end
    end

    // pointer, start and counter next values
    always_comb begin
        ptr_next = ptr_reg;
        if (cmd.load_item) begin
            ptr_next = ((s_operation == OP_FREE) || (s_operation == OP_RESERVE)) ?
                       CW'(s_frame_index) : '0;
        end else if (cmd.ptr_from_s) begin
            ptr_next = s_reg[CW-1:0];
        end else if (cmd.issue_rd || cmd.clr_wr || cmd.fill_wr) begin
            ptr_next = ptr_reg + CW'(1);
        end

        s_next = s_reg;
        if (cmd.load_item) begin
            s_next = '0;
        end else if (cmd.s_step) begin
            s_next = s_reg + SW'(step_eff);
        end

        acc_next = acc_reg;
        if (cmd.load_item || cmd.acc_clr) begin
            acc_next = '0;
        end else if (cmd.zero_acc && chk_vld_reg && (rdata_reg == '0)) begin
            acc_next = acc_reg + CW'(1);
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg     <= '0;
            chk_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            ptr_reg     <= ptr_next;
            chk_vld_reg <= cmd.issue_rd;
            if (cmd.res_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // item and working registers
    always_ff @(posedge aclk) begin
        s_reg   <= s_next;
        acc_reg <= acc_next;
        if (cmd.load_item) begin
            op_reg   <= op_t'(s_operation);
            idx_reg  <= s_frame_index;
            len_reg  <= s_run_length;
            step_reg <= s_align_step;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            success_reg <= cmd.res_ok;
            first_reg   <= (cmd.res_ok && (op_reg == OP_ALLOC)) ? s_reg[INDEX_W-1:0] : '0;
            free_reg    <= (op_reg == OP_COUNT) ? acc_reg[TOTAL_W-1:0] : '0;
            used_reg    <= (op_reg == OP_COUNT) ? used_w[TOTAL_W-1:0] : '0;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_success     = success_reg;
    assign m_first_frame = first_reg;
    assign m_free_total  = free_reg;
    assign m_used_total  = used_reg;

`ifndef SYNTHESIS
    // write-back never lands on the entry being read in the same cycle
    a_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && cmd.issue_rd) |-> (wr_addr != ptr_reg[AW-1:0]))
        else $error("table write and read at the same entry");

    // the free-run counter never passes the requested run length
    a_run_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (op_reg == OP_ALLOC) |-> (SW'(acc_reg) <= len_w))
        else $error("free run counter exceeds run length");
`endif

endmodule

/* tb/sv/refcounted_page_frame_allocator_test.sv */
// ----------------------------------------------------------------------------
// refcounted_page_frame_allocator_test
// Self-checking bench for the page frame allocator. A shadow copy of the
// reference count table predicts every status from the accepted operations.
// Stimulus is a directed opening, randomised phases over a range of managed
// frame counts with sender gaps and receiver stalls, and a short closing
// sequence on a single managed frame.
// ----------------------------------------------------------------------------
module refcounted_page_frame_allocator_test;
    import pfa_pkg::*;

    localparam int FRAMES  = NUM_FRAMES_DEF;
    localparam int COUNT_W = COUNT_WIDTH_DEF;

    // one status as returned on the m_ channel
    typedef struct packed {
        logic               success;
        logic [INDEX_W-1:0] first_frame;
        logic [TOTAL_W-1:0] free_total;
        logic [TOTAL_W-1:0] used_total;
    } frame_status_t;

    // shadow of the count table, with the queue of statuses still owed
    class refcount_shadow;
        bit [COUNT_W-1:0]  ref_count [FRAMES];
        bit [TOTAL_W-1:0]  frames_reg;
        frame_status_t     expected_status [$];
        int                failures;

        function new();
            foreach (ref_count[i]) ref_count[i] = '0;
            frames_reg = FRAMES_RESET;
            failures   = 0;
        endfunction

        function void write_frames(bit [TOTAL_W-1:0] value);
            frames_reg = value;
        endfunction

        function int managed();
            return (frames_reg > FRAMES) ? FRAMES : int'(frames_reg);
        endfunction

        function bit run_clear(int start, int len);
            for (int i = 0; i < len; i++)
                if (ref_count[start + i] != 0) return 1'b0;
            return 1'b1;
        endfunction

        // apply one accepted operation and queue the status it produces
        function void note_operation(op_t op, bit [INDEX_W-1:0] idx,
                                     bit [LEN_W-1:0] len, bit [LEN_W-1:0] step);
            frame_status_t st;
            int total;
            int stride;
            int f;
            int n_free;
            total  = managed();
            stride = (step == 0) ? 1 : int'(step);
            st     = '0;
            st.success = 1'b1;
            case (op)
                OP_ALLOC: begin
                    st.success = 1'b0;
                    if (len != 0 && len <= total) begin
                        for (int s = 0; s + len <= total; s += stride) begin
                            if (run_clear(s, len)) begin
                                for (int i = 0; i < len; i++) ref_count[s + i] = 1;
                                st.success     = 1'b1;
                                st.first_frame = s[INDEX_W-1:0];
                                break;
                            end
                        end
                    end
                end
                OP_FREE: begin
                    for (int i = 0; i < len; i++) begin
                        f = int'(idx) + i;
                        if (f < total && ref_count[f] != 0) ref_count[f]--;
                    end
                end
                OP_RESERVE: begin
                    for (int i = 0; i < len; i++) begin
                        f = int'(idx) + i;
                        if (f < total && ref_count[f] != '1) ref_count[f]++;
                    end
                end
                default: begin
                    n_free = 0;
                    for (int i = 0; i < total; i++)
                        if (ref_count[i] == 0) n_free++;
                    st.free_total = n_free[TOTAL_W-1:0];
                    st.used_total = TOTAL_W'(total - n_free);
                end
            endcase
            expected_status.push_back(st);
        endfunction

        function void note_failure(string msg);
            failures++;
            if (failures <= 10) $display("%s", msg);
        endfunction

        // compare one delivered status with the oldest one owed
        function void check_status(frame_status_t got);
            frame_status_t want;
            if (expected_status.size() == 0) begin
                note_failure($sformatf(
                    "unexpected status: success=%0d first=%0d free=%0d used=%0d",
                    got.success, got.first_frame, got.free_total, got.used_total));
                return;
            end
            want = expected_status.pop_front();
            if (got.success !== want.success || got.first_frame !== want.first_frame ||
                got.free_total !== want.free_total || got.used_total !== want.used_total)
                note_failure($sformatf(
                    "status mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                    want.success, want.first_frame, want.free_total, want.used_total,
                    got.success, got.first_frame, got.free_total, got.used_total));
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [TOTAL_W-1:0] cfg_data;
    logic               s_valid;
    logic               s_ready;
    logic [OP_W-1:0]    s_operation;
    logic [INDEX_W-1:0] s_frame_index;
    logic [LEN_W-1:0]   s_run_length;
    logic [LEN_W-1:0]   s_align_step;
    logic               m_valid;
    logic               m_ready;
    logic               m_success;
    logic [INDEX_W-1:0] m_first_frame;
    logic [TOTAL_W-1:0] m_free_total;
    logic [TOTAL_W-1:0] m_used_total;

    refcount_shadow shadow = new();

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int hold_cycles        = 0;

    int phase_frames [13] = '{64, 1, 0, 2047, 37, 2, 128, 1024, 200, 1025, 16, 1000, 300};
    int phase_items  [13] = '{80, 30, 20, 15, 80, 30, 80, 15, 60, 10, 80, 15, 50};

    refcounted_page_frame_allocator DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_frame_index (s_frame_index),
        .s_run_length  (s_run_length),
        .s_align_step  (s_align_step),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_success     (m_success),
        .m_first_frame (m_first_frame),
        .m_free_total  (m_free_total),
        .m_used_total  (m_used_total)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // run limit
    initial begin
        #100_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // receiver: random stalls, plus a long hold-off when requested
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    // monitor: statuses are checked before the new transaction is noted
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                shadow.check_status({m_success, m_first_frame, m_free_total, m_used_total});
            if (s_valid && s_ready)
                shadow.note_operation(op_t'(s_operation), s_frame_index, s_run_length,
                                      s_align_step);
            if (cfg_valid && cfg_ready)
                shadow.write_frames(cfg_data);
        end
    end

    // offer one operation and hold it until the transaction completes
    task automatic send_operation(input op_t op, input logic [INDEX_W-1:0] idx,
                                  input logic [LEN_W-1:0] len,
                                  input logic [LEN_W-1:0] step);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_operation   <= op;
        s_frame_index <= idx;
        s_run_length  <= len;
        s_align_step  <= step;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic stop_sending();
        s_valid <= 1'b0;
    endtask

    // wait until every owed status has been delivered
    task automatic wait_drained();
        do @(posedge aclk); while (shadow.expected_status.size() != 0);
    endtask

    task automatic write_frames_reg(input logic [TOTAL_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_idling(input int mode);
        case (mode % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 70; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 70; end
            default: begin sender_idle_pct = 17; receiver_stall_pct = 17; end
        endcase
    endtask

    // random operation, lengths scaled to the managed frame count
    task automatic send_random_operation(input int m);
        op_t                op;
        logic [INDEX_W-1:0] idx;
        logic [LEN_W-1:0]   len;
        logic [LEN_W-1:0]   step;
        int                 pick;
        int                 idx_hi;
        pick = $urandom_range(99);
        op = (pick < 35) ? OP_ALLOC : (pick < 65) ? OP_FREE :
             (pick < 85) ? OP_RESERVE : OP_COUNT;
        pick = $urandom_range(99);
        if (pick < 5)       len = '0;
        else if (pick < 8)  len = LEN_W'($urandom_range(1024, 2047));
        else if (pick < 15) len = LEN_W'($urandom_range(1, 1024));
        else                len = LEN_W'($urandom_range(1, m / 4 + 1));
        idx_hi = (m + 3 > FRAMES - 1) ? FRAMES - 1 : m + 3;
        idx = ($urandom_range(99) < 70) ? INDEX_W'($urandom_range(0, idx_hi))
                                        : INDEX_W'($urandom_range(0, FRAMES - 1));
        pick = $urandom_range(99);
        if (pick < 50)      step = LEN_W'($urandom_range(0, 3));
        else if (pick < 80) step = 11'd1 << $urandom_range(0, 10);
        else                step = LEN_W'($urandom_range(0, 2047));
        send_operation(op, idx, len, step);
    endtask

    // directed opening on the full table
    task automatic run_directed();
        send_operation(OP_COUNT,   10'd0,    11'd0,    11'd0);
        send_operation(OP_ALLOC,   10'd0,    11'd1,    11'd0);
        send_operation(OP_ALLOC,   10'd0,    11'd1024, 11'd1);
        send_operation(OP_ALLOC,   10'd0,    11'd0,    11'd1);
        send_operation(OP_FREE,    10'd5,    11'd0,    11'd0);
        send_operation(OP_RESERVE, 10'd5,    11'd0,    11'd0);
        send_operation(OP_ALLOC,   10'd0,    11'd3,    11'd4);
        send_operation(OP_ALLOC,   10'd0,    11'd2,    11'd1024);
        send_operation(OP_ALLOC,   10'd0,    11'd1023, 11'd0);
        send_operation(OP_FREE,    10'd0,    11'd1,    11'd0);
        // free of a frame already at zero
        send_operation(OP_FREE,    10'd0,    11'd1,    11'd0);
        // runs reaching past the managed frames
        send_operation(OP_RESERVE, 10'd1020, 11'd1024, 11'd0);
        send_operation(OP_RESERVE, 10'd1023, 11'd2047, 11'd2047);
        send_operation(OP_COUNT,   10'd1023, 11'd2047, 11'd2047);
        send_operation(OP_FREE,    10'd1020, 11'd4,    11'd0);
        send_operation(OP_FREE,    10'd1020, 11'd4,    11'd0);
        send_operation(OP_ALLOC,   10'd0,    11'd1024, 11'd2047);
        send_operation(OP_FREE,    10'd4,    11'd3,    11'd0);
        send_operation(OP_ALLOC,   10'd0,    11'd1024, 11'd1024);
        send_operation(OP_COUNT,   10'd0,    11'd0,    11'd0);
        send_operation(OP_FREE,    10'd0,    11'd1024, 11'd0);
        // aligned search where a failed try moves to the next aligned start
        send_operation(OP_ALLOC,   10'd0,    11'd1,    11'd0);
        send_operation(OP_ALLOC,   10'd0,    11'd512,  11'd512);
        send_operation(OP_ALLOC,   10'd0,    11'd512,  11'd512);
        send_operation(OP_COUNT,   10'd0,    11'd0,    11'd0);
    endtask

    // stimulus
    initial begin
        int m;
        aresetn       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        s_valid       = 1'b0;
        s_operation   = '0;
        s_frame_index = '0;
        s_run_length  = '0;
        s_align_step  = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        run_directed();

        foreach (phase_frames[p]) begin
            stop_sending();
            wait_drained();
            write_frames_reg(TOTAL_W'(phase_frames[p]));
            set_idling(p);
            m = (phase_frames[p] > FRAMES) ? FRAMES : phase_frames[p];
            for (int i = 0; i < phase_items[p]; i++) begin
                // sender waits for the block to empty once
                if (p == 0 && i == phase_items[p] / 2) begin
                    stop_sending();
                    wait_drained();
                end
                // long receiver hold-off while the sender keeps offering
                if (p == 4 && i == phase_items[p] / 2) hold_cycles = 3000;
                send_random_operation(m);
            end
        end

        // closing sequence on a single managed frame
        stop_sending();
        wait_drained();
        write_frames_reg(11'd1);
        set_idling(0);
        send_operation(OP_RESERVE, 10'd0, 11'd1, 11'd0);
        send_operation(OP_RESERVE, 10'd0, 11'd2, 11'd0);
        send_operation(OP_COUNT,   10'd0, 11'd0, 11'd0);
        send_operation(OP_FREE,    10'd0, 11'd1, 11'd0);
        send_operation(OP_COUNT,   10'd0, 11'd0, 11'd0);

        // drain, then allow for stray statuses
        stop_sending();
        wait_drained();
        repeat (3500) @(posedge aclk);
        if (shadow.expected_status.size() != 0)
            shadow.note_failure($sformatf("%0d statuses never delivered",
                                          shadow.expected_status.size()));
        if (shadow.failures == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
